/* rtl/core/dss_pkg.sv */
// Shared constants, types and value conversions of the descending selection sorter.
package dss_pkg;

  localparam int MAX_COUNT  = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PORT_W     = 32;
  localparam int EXT_W      = 64;
  localparam int ADDR_W     = $clog2(MAX_COUNT);
  localparam int CNT_W      = $clog2(MAX_COUNT + 1);

  typedef logic signed [DATA_WIDTH-1:0] value_t;
  typedef logic [PORT_W-1:0]            port_word_t;
  typedef logic [ADDR_W-1:0]            addr_t;
  typedef logic [CNT_W-1:0]             count_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic emit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic set_closed;
    logic scan_done;
    logic out_free;
    logic last_pass;
  } status_t;

  // Sign-extend the port word, then keep the value width.
  function automatic value_t to_value(input port_word_t s);
    logic signed [EXT_W-1:0] w;
    w = EXT_W'(signed'(s));
    return w[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a value, then keep the port width.
  function automatic port_word_t to_port(input value_t v);
    logic signed [EXT_W-1:0] w;
    w = EXT_W'(v);
    return w[PORT_W-1:0];
  endfunction

endpackage

/* rtl/core/dss_if.sv */
// Request channel interfaces for samples in and ranked values out.
interface dss_in_if;
  logic                 valid;
  logic                 ready;
  dss_pkg::port_word_t  sample;
  logic                 final_req;

  modport source (output valid, output sample, output final_req, input ready);
  modport sink   (input valid, input sample, input final_req, output ready);
endinterface

interface dss_out_if;
  logic                 valid;
  logic                 ready;
  dss_pkg::port_word_t  ranked;
  logic                 closing;
  logic                 truncated;

  modport source (output valid, output ranked, output closing, output truncated,
                  input ready);
  modport sink   (input valid, input ranked, input closing, input truncated,
                  output ready);
endinterface

/* rtl/core/descending_selection_sorter_top.sv */
// Top level of the descending selection sorter: controller plus datapath.
// Loading: one sample request per cycle in the load phase; a sample arriving with the
//   store full is dropped. Sorting a set of n values: pass i scans entries i..n-1
//   through the single registered read port of the store, one result per pass.
// Reset (rst, synchronous): clears the state machine, fill count, drop flag and output valid;
//   the store itself is not cleared and needs no clearing pass.
module descending_selection_sorter_top (
  input  logic      clk,
  input  logic      rst,
  dss_in_if.sink    din,
  dss_out_if.source dout
);

  // Commands flow down, status flows up; nothing else joins the two halves.
  dss_pkg::cmd_t    cmd;
  dss_pkg::status_t status;

  // Sequence load, scan and emit phases.
  dss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .cmd    (cmd)
  );

  // Hold the store, track the running maximum and drive the result register.
  // The result register lets the next set start loading while the last
  // result of the previous set still waits to be taken.
  dss_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .status (status),
    .din    (din),
    .dout   (dout)
  );

endmodule

/* rtl/core/dss_ctrl.sv */
// Sequencing state machine: load, scan for the maximum, emit it.
module dss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  dss_pkg::status_t status,
  output dss_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    LOAD = 3'b001,
    SCAN = 3'b010,
    EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      LOAD: begin
        if (status.set_closed) state_next = SCAN;
      end
      SCAN: begin
        if (status.scan_done) state_next = EMIT;
      end
      EMIT: begin
        if (status.out_free) state_next = status.last_pass ? LOAD : SCAN;
      end
      default: state_next = LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= LOAD;
    else     state <= state_next;
  end

  always_comb begin
    cmd.load = (state == LOAD);
    cmd.scan = (state == SCAN);
    cmd.emit = (state == EMIT) && status.out_free;
  end

endmodule

/* rtl/core/dss_datapath.sv */
// Store, scan pipeline, maximum tracker and output register.
module dss_datapath (
  input  logic           clk,
  input  logic           rst,
  input  dss_pkg::cmd_t  cmd,
  output dss_pkg::status_t status,
  dss_in_if.sink         din,
  dss_out_if.source      dout
);

  dss_pkg::value_t mem [dss_pkg::MAX_COUNT];

  dss_pkg::count_t fill_count;
  logic            dropped;
  dss_pkg::count_t pass_end;
  logic            trunc;
  dss_pkg::count_t base;
  dss_pkg::count_t scan_idx;
  logic            rd_vld;
  dss_pkg::addr_t  rd_idx;
  dss_pkg::value_t rd_data;
  dss_pkg::value_t best_val;
  dss_pkg::addr_t  best_idx;
  dss_pkg::value_t head_val;
  logic            out_valid;

  logic            in_take;
  logic            has_room;
  logic            rd_en;
  logic            wr_en;
  dss_pkg::addr_t  wr_addr;
  dss_pkg::value_t wr_data;
  dss_pkg::count_t fill_next;
  dss_pkg::count_t base_inc;

  assign din.ready  = cmd.load;
  assign in_take    = din.valid && cmd.load;
  assign has_room   = fill_count < dss_pkg::count_t'(dss_pkg::MAX_COUNT);
  assign fill_next  = has_room ? fill_count + 1'b1 : fill_count;
  assign base_inc   = base + 1'b1;
  assign rd_en      = cmd.scan && (scan_idx < pass_end);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_count[dss_pkg::ADDR_W-1:0];
    wr_data = dss_pkg::to_value(din.sample);
    if (in_take && has_room) begin
      wr_en = 1'b1;
    end else if (cmd.emit) begin
      // Move the old head into the slot the maximum leaves.
      wr_en   = 1'b1;
      wr_addr = best_idx;
      wr_data = head_val;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[scan_idx[dss_pkg::ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      dropped    <= 1'b0;
      pass_end   <= '0;
      trunc      <= 1'b0;
      base       <= '0;
      scan_idx   <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_take) begin
        if (din.final_req) begin
          pass_end   <= fill_next;
          trunc      <= dropped || !has_room;
          fill_count <= '0;
          dropped    <= 1'b0;
          base       <= '0;
          scan_idx   <= '0;
          rd_vld     <= 1'b0;
        end else begin
          fill_count <= fill_next;
          if (!has_room) dropped <= 1'b1;
        end
      end
      if (cmd.scan) begin
        rd_vld <= rd_en;
        if (rd_en) scan_idx <= scan_idx + 1'b1;
      end
      if (cmd.emit) begin
        base     <= base_inc;
        scan_idx <= base_inc;
        rd_vld   <= 1'b0;
      end
      if (cmd.emit)        out_valid <= 1'b1;
      else if (dout.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_idx <= scan_idx[dss_pkg::ADDR_W-1:0];
    if (cmd.scan && rd_vld) begin
      if (rd_idx == base[dss_pkg::ADDR_W-1:0]) begin
        head_val <= rd_data;
        best_val <= rd_data;
        best_idx <= rd_idx;
      end else if (rd_data > best_val) begin
        best_val <= rd_data;
        best_idx <= rd_idx;
      end
    end
    if (cmd.emit) begin
      dout.ranked    <= dss_pkg::to_port(best_val);
      dout.closing   <= status.last_pass;
      dout.truncated <= trunc;
    end
  end

  assign dout.valid = out_valid;

  always_comb begin
    status.set_closed = in_take && din.final_req;
    status.scan_done  = (scan_idx == pass_end) && !rd_vld;
    status.out_free   = !out_valid || dout.ready;
    status.last_pass  = (base_inc == pass_end);
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= dss_pkg::count_t'(dss_pkg::MAX_COUNT))
    else $error("fill count beyond capacity");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan |-> (scan_idx <= pass_end) && (base < pass_end))
    else $error("scan index past end of set");

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted result not presented");

  a_close_empty: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.last_pass) |=> (fill_count == '0) && !dropped)
    else $error("store not empty after closing result");

endmodule

/* tb/tb_descending_selection_sorter_top.sv */
// Self-checking testbench: streams sample sets and checks every ranked request.
module tb_descending_selection_sorter_top;
  timeunit 1ns;
  timeprecision 1ps;

  // One sample request as queued for the driver.
  typedef struct {
    dss_pkg::port_word_t sample;
    logic                final_req;
  } sample_req_t;

  // One ranked request as the block must emit it.
  typedef struct {
    dss_pkg::port_word_t ranked;
    logic                closing;
    logic                truncated;
  } ranked_req_t;

  // Idling patterns, one per phase of the run.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // Within a set, the gap between two ranked requests is at most one pass
  // plus receiver stalls.
  localparam int WATCHDOG_LIMIT = 20000;
  // Quiet cycles after the last ranked request, to catch stray outputs.
  localparam int DRAIN_CYCLES   = 300;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int SHOWN_ERRORS   = 20;

  localparam dss_pkg::port_word_t MAX_SAMPLE = {1'b0, {(dss_pkg::PORT_W-1){1'b1}}};
  localparam dss_pkg::port_word_t MIN_SAMPLE = {1'b1, {(dss_pkg::PORT_W-1){1'b0}}};

  logic clk;
  logic rst = 1'b1;

  dss_in_if  din();
  dss_out_if dout();

  descending_selection_sorter_top dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  // Stimulus waiting for the driver, and ranked requests waiting for the block.
  sample_req_t sample_pending_q[$];
  ranked_req_t ranked_expect_q[$];

  // Predictor copy of the store contents and the drop flag of the open set.
  dss_pkg::value_t held_values[$];
  logic            held_dropped = 1'b0;

  idle_mode_t          idle_mode = IDLE_NONE;
  dss_pkg::port_word_t last_sample = '0;

  int items_queued   = 0;
  int items_accepted = 0;
  int sets_closed    = 0;
  int trunc_sets     = 0;
  int results_seen   = 0;
  int errors         = 0;
  int quiet_cycles   = 0;

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Absorb one accepted sample request into the open set. On the request
  // that closes the set, rank the held values largest first and queue one
  // expected ranked request per value, then empty the set.
  function automatic void absorb_sample(input dss_pkg::port_word_t s, input logic fin);
    dss_pkg::value_t                  v;
    dss_pkg::value_t                  pool[$];
    logic signed [dss_pkg::EXT_W-1:0] wide;
    ranked_req_t                      r;
    int                               best;
    int                               n;
    // Sign-extend from the port width, then keep the value width.
    v = signed'(s);
    // A full store drops the sample, even on the closing request.
    if (held_values.size() < dss_pkg::MAX_COUNT)
      held_values.push_back(v);
    else
      held_dropped = 1'b1;
    if (fin) begin
      pool = held_values;
      n = pool.size();
      for (int i = 0; i < n; i++) begin
        // Pick the largest remaining value; equal values are indistinguishable.
        best = 0;
        for (int j = 1; j < pool.size(); j++)
          if (pool[j] > pool[best])
            best = j;
        wide = pool[best];
        r.ranked    = wide[dss_pkg::PORT_W-1:0];
        r.closing   = (i == n - 1);
        r.truncated = held_dropped;
        ranked_expect_q.push_back(r);
        pool.delete(best);
      end
      sets_closed++;
      if (held_dropped)
        trunc_sets++;
      held_values.delete();
      held_dropped = 1'b0;
    end
  endfunction

  // Full-range values in four draws of ten, with small values for ties, the extremes,
  // values near the extremes and straight repeats of the previous one.
  function automatic dss_pkg::port_word_t rand_sample();
    dss_pkg::port_word_t s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = dss_pkg::port_word_t'($urandom);
      4, 5:       s = dss_pkg::port_word_t'($urandom_range(0, 15)) - dss_pkg::port_word_t'(8);
      6: begin
        case ($urandom_range(0, 3))
          0:       s = MAX_SAMPLE;
          1:       s = MIN_SAMPLE;
          2:       s = '0;
          default: s = '1;
        endcase
      end
      7: begin
        if ($urandom_range(0, 1))
          s = MAX_SAMPLE - dss_pkg::port_word_t'($urandom_range(0, 3));
        else
          s = MIN_SAMPLE + dss_pkg::port_word_t'($urandom_range(0, 3));
      end
      default: s = last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  function automatic void add_item(input dss_pkg::port_word_t s, input logic fin);
    sample_req_t it;
    it.sample    = s;
    it.final_req = fin;
    sample_pending_q.push_back(it);
    items_queued++;
  endfunction

  // Queue a set of n random samples; the last one closes the set.
  function automatic void add_set(input int n);
    for (int i = 0; i < n; i++)
      add_item(rand_sample(), i == n - 1);
  endfunction

  function automatic logic sender_idle();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(0, 99) < 55;
      IDLE_BOTH:   return $urandom_range(0, 99) < 10;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic logic receiver_stall();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(0, 99) < 55;
      IDLE_BOTH:     return $urandom_range(0, 99) < 10;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic void check_field(input string name, input dss_pkg::port_word_t want,
                                      input dss_pkg::port_word_t got);
    if (got !== want) begin
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Driver: hold a request until it is taken, then advance to the next
  // queued one unless the sender idles this cycle. The predictor sees each
  // request on the edge where it is accepted.
  always @(posedge clk) begin : drive
    sample_req_t nxt;
    if (rst) begin
      din.valid     <= 1'b0;
      din.sample    <= '0;
      din.final_req <= 1'b0;
    end else begin
      if (din.valid && din.ready) begin
        items_accepted++;
        absorb_sample(din.sample, din.final_req);
      end
      if (!din.valid || din.ready) begin
        if (sample_pending_q.size() != 0 && !sender_idle()) begin
          nxt = sample_pending_q.pop_front();
          din.valid     <= 1'b1;
          din.sample    <= nxt.sample;
          din.final_req <= nxt.final_req;
        end else begin
          din.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare every accepted ranked request with the oldest expected
  // one, field by field; a request with nothing expected is a failure.
  always @(posedge clk) begin : monitor
    ranked_req_t want;
    if (rst) begin
      dout.ready <= 1'b0;
    end else begin
      if (dout.valid && dout.ready) begin
        results_seen++;
        if (ranked_expect_q.size() == 0) begin
          errors++;
          if (errors <= SHOWN_ERRORS)
            $display("%0t ns: unexpected ranked request, expected none, actual %h %b %b",
                     $time, dout.ranked, dout.closing, dout.truncated);
        end else begin
          want = ranked_expect_q.pop_front();
          check_field("ranked", want.ranked, dout.ranked);
          check_field("closing", dss_pkg::port_word_t'(want.closing),
                      dss_pkg::port_word_t'(dout.closing));
          check_field("truncated", dss_pkg::port_word_t'(want.truncated),
                      dss_pkg::port_word_t'(dout.truncated));
        end
      end
      dout.ready <= !receiver_stall();
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((din.valid && din.ready) || (dout.valid && dout.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no request moved for %0d cycles, %0d ranked requests outstanding",
                 WATCHDOG_LIMIT, ranked_expect_q.size());
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int goal;
    int n;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 4; p++) begin
      idle_mode = idle_mode_t'(p);
      case (idle_mode)
        IDLE_NONE: begin
          // Single-element sets at the extremes, zero and minus one.
          add_item(MAX_SAMPLE, 1'b1);
          add_item(MIN_SAMPLE, 1'b1);
          add_item('0, 1'b1);
          add_item('1, 1'b1);
          // Both extremes twice, mixed with zero and minus one.
          add_item(MIN_SAMPLE, 1'b0);
          add_item(MAX_SAMPLE, 1'b0);
          add_item('0, 1'b0);
          add_item('1, 1'b0);
          add_item(MAX_SAMPLE, 1'b0);
          add_item(MIN_SAMPLE, 1'b1);
          // All values equal.
          add_item(dss_pkg::port_word_t'(5), 1'b0);
          add_item(dss_pkg::port_word_t'(5), 1'b0);
          add_item(dss_pkg::port_word_t'(5), 1'b1);
          // Ties between negatives, sign crossing.
          add_item(-dss_pkg::port_word_t'(3), 1'b0);
          add_item(dss_pkg::port_word_t'(7), 1'b0);
          add_item(-dss_pkg::port_word_t'(3), 1'b0);
          add_item('0, 1'b1);
        end
        // Exactly full store: no drop.
        IDLE_SENDER:   add_set(dss_pkg::MAX_COUNT);
        // Full store when the closing request arrives: the closer itself is dropped.
        IDLE_RECEIVER: add_set(dss_pkg::MAX_COUNT + 1);
        // Several samples dropped before the closer.
        default:       add_set(dss_pkg::MAX_COUNT + 8);
      endcase

      // Random sets, mostly small so that results come often; now and then
      // one near or past the store size.
      goal = items_queued + ITEMS_PER_PHASE;
      while (items_queued < goal) begin
        if ($urandom_range(0, 19) == 0)
          n = $urandom_range(dss_pkg::MAX_COUNT - 4, dss_pkg::MAX_COUNT + 6);
        else
          n = $urandom_range(1, 10);
        add_set(n);
      end

      // Drain: every queued request sent and every ranked request back.
      while (sample_pending_q.size() != 0 || din.valid || ranked_expect_q.size() != 0)
        @(negedge clk);
    end

    // Quiet period to catch stray ranked requests.
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d sample requests in %0d sets, %0d of them over capacity;",
             items_accepted, sets_closed, trunc_sets);
    $display("checked %0d ranked requests under four idling patterns, %0d errors.",
             results_seen, errors);
    if (errors == 0 && ranked_expect_q.size() == 0 && held_values.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
